FILE: rtl/tilt_angle_led_level_defines.svh
// Assertion macros for the tilt angle LED level RTL.
`ifndef TILT_ANGLE_LED_LEVEL_DEFINES_SVH
`define TILT_ANGLE_LED_LEVEL_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define TAL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check that a condition in one cycle leads to another in the next cycle.
`define TAL_ASSERT_NEXT(label, ante, cons, msg) \
    `TAL_ASSERT(label, (ante) |=> (cons), msg)

`endif

FILE: rtl/tal_pkg.sv
// Shared types, constants and tables of the tilt angle LED level block.
`default_nettype none
package tal_pkg;

    localparam int ACC_W      = 16;
    localparam int NUM_W      = ACC_W + 1;
    localparam int SUM_W      = 2 * ACC_W;
    localparam int DEN_W      = ACC_W;
    localparam int REM_W      = DEN_W + 2;
    localparam int SQRT_STEPS = SUM_W / 2;
    localparam int CORDIC_STEPS = 16;
    localparam int WORK_SHIFT = 16;
    localparam int XY_W       = 35;
    localparam int Z_W        = 22;
    localparam int ZC_W       = 20;
    localparam int MAG_W      = 14;
    localparam int DIFF_W     = 16;
    localparam int DEG_W      = 8;
    localparam int LEVEL_W    = 10;
    localparam int TGT_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_TILT_AXIS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_ANGLE = 1'd1;

    // Angle scaling: Z is in 0.0001 degree, results in 0.01 degree.
    localparam logic [ZC_W-1:0]  Z_MAX       = 20'd900000;
    localparam logic [ZC_W-1:0]  Z_ROUND     = 20'd50;
    localparam logic [MAG_W-1:0] MAG_FULL    = 14'd9000;
    localparam int               RECIP_W     = 26;
    localparam logic [RECIP_W-1:0] RECIP_100 = 26'd42949673;  // ceil(2^32 / 100)
    localparam int               RECIP_100_SH = 32;
    localparam int               RECIP9_W    = 21;
    localparam logic [RECIP9_W-1:0] RECIP_9  = 21'd1864136;   // ceil(2^24 / 9)
    localparam int               RECIP_9_SH  = 24;
    localparam int               LV_W        = 14;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 10'd999;

    // atan(2^-i) in 0.0001 degree.
    localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        22'sd450000, 22'sd265651, 22'sd140362, 22'sd71250,
        22'sd35763,  22'sd17899,  22'sd8952,   22'sd4476,
        22'sd2238,   22'sd1119,   22'sd560,    22'sd280,
        22'sd140,    22'sd70,     22'sd35,     22'sd17
    };

    typedef struct packed {
        logic                    axis;
        logic signed [TGT_W-1:0] target;
        logic                    num_neg;
        logic                    num_zero;
        logic                    den_zero;
        logic [ACC_W-1:0]        num_abs;
    } tal_side_t;

endpackage
`default_nettype wire

FILE: rtl/tilt_angle_led_level.sv
// Top level of the tilt angle LED level block.
// Pipeline: 39 register stages (3 front, 16 square root, 16 CORDIC, 4 scaling).
// Throughput: one item per cycle; every stage has its own valid bit and loads
//   whenever it is empty or its successor moves, so bubbles close up on a stall.
// Reset: aresetn synchronous, active low; clears all valid bits, sets pitch mode
//   and a target of zero degrees.
`default_nettype none
module tilt_angle_led_level (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Configuration writes
    input  wire logic                               cfg_wr_en,
    input  wire logic [tal_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tal_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Sample input
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [47:0]                        s_tdata,  // accel_x, accel_y, accel_z
    // Result output
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // green_level, orange_level, red_level, blue_level, angle_magnitude,
    // angle_positive, one pad bit
    output logic [55:0]                             m_tdata
);
    logic                             tilt_axis_reg;
    logic signed [tal_pkg::TGT_W-1:0] target_angle_reg;

    logic                       fr_valid, fr_ready;
    logic [tal_pkg::SUM_W-1:0]  fr_sum;
    tal_pkg::tal_side_t         fr_side;

    logic                       sq_valid, sq_ready;
    logic [tal_pkg::DEN_W-1:0]  sq_den;
    tal_pkg::tal_side_t         sq_side;

    logic                              co_valid, co_ready;
    logic signed [tal_pkg::Z_W-1:0]    co_z;
    tal_pkg::tal_side_t                co_side;

    logic [tal_pkg::LEVEL_W-1:0] green_level, orange_level, red_level, blue_level;
    logic [tal_pkg::MAG_W-1:0]   angle_magnitude;
    logic                        angle_positive;

    // Register file: the user must write only while no item is in flight; the block does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tilt_axis_reg    <= 1'b1;
            target_angle_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tal_pkg::REG_TILT_AXIS:    tilt_axis_reg    <= cfg_wdata[0];
                tal_pkg::REG_TARGET_ANGLE: target_angle_reg <= cfg_wdata[tal_pkg::TGT_W-1:0];
                default: ;
            endcase
        end
    end

    // Select axes and form the sum of squares under the square root.
    tal_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_x      (s_tdata[15:0]),
        .in_y      (s_tdata[31:16]),
        .in_z      (s_tdata[47:32]),
        .axis      (tilt_axis_reg),
        .target    (target_angle_reg),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_sum   (fr_sum),
        .out_side  (fr_side)
    );

    // Floor square root gives the divisor of the arctangent.
    tal_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_sum    (fr_sum),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_den   (sq_den),
        .out_side  (sq_side)
    );

    // Arctangent of |numerator| over divisor, in 0.0001 degree.
    tal_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sq_valid),
        .in_ready  (sq_ready),
        .in_den    (sq_den),
        .in_side   (sq_side),
        .out_valid (co_valid),
        .out_ready (co_ready),
        .out_z     (co_z),
        .out_side  (co_side)
    );

    // Round to 0.01 degree, apply special cases and build the LED levels.
    // Its last stage is the output register that parts the result side.
    tal_post u_post (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (co_valid),
        .in_ready        (co_ready),
        .in_z            (co_z),
        .in_side         (co_side),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .green_level     (green_level),
        .orange_level    (orange_level),
        .red_level       (red_level),
        .blue_level      (blue_level),
        .angle_magnitude (angle_magnitude),
        .angle_positive  (angle_positive)
    );

    // Pack the result item, lowest field first.
    assign m_tdata = {1'b0, angle_positive, angle_magnitude,
                      blue_level, red_level, orange_level, green_level};
endmodule
`default_nettype wire

FILE: rtl/tal_front.sv
// Front stages: pick numerator and axes, square them and sum the squares.
`default_nettype none
module tal_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [tal_pkg::ACC_W-1:0] in_x,
    input  wire logic signed [tal_pkg::ACC_W-1:0] in_y,
    input  wire logic signed [tal_pkg::ACC_W-1:0] in_z,
    input  wire logic                           axis,
    input  wire logic signed [tal_pkg::TGT_W-1:0] target,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [tal_pkg::SUM_W-1:0]           out_sum,
    output tal_pkg::tal_side_t                  out_side
);
    logic [2:0] v_reg;
    logic [2:0] adv;

    logic signed [tal_pkg::NUM_W-1:0] num0_reg;
    logic signed [tal_pkg::ACC_W-1:0] a0_reg, b0_reg;
    logic                             axis0_reg;
    logic signed [tal_pkg::TGT_W-1:0] target0_reg;
    logic signed [tal_pkg::NUM_W-1:0] num0_next;

    logic [tal_pkg::SUM_W-1:0] sqa1_reg, sqb1_reg;
    tal_pkg::tal_side_t        side1_reg, side1_next;
    logic signed [tal_pkg::SUM_W-1:0] pa, pb;
    logic [tal_pkg::NUM_W-1:0] num0_neg;

    logic [tal_pkg::SUM_W-1:0] sum2_reg;
    tal_pkg::tal_side_t        side2_reg;

    assign adv[2]   = !v_reg[2] || out_ready;
    assign adv[1]   = !v_reg[1] || adv[2];
    assign adv[0]   = !v_reg[0] || adv[1];
    assign in_ready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) v_reg[0] <= in_valid;
            if (adv[1]) v_reg[1] <= v_reg[0];
            if (adv[2]) v_reg[2] <= v_reg[1];
        end
    end

    // Pitch uses x over y and z, roll uses -y over x and z.
    always_comb begin
        if (axis) begin
            num0_next = {in_x[tal_pkg::ACC_W-1], in_x};
        end else begin
            num0_next = -{in_y[tal_pkg::ACC_W-1], in_y};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            num0_reg    <= num0_next;
            a0_reg      <= axis ? in_y : in_x;
            b0_reg      <= in_z;
            axis0_reg   <= axis;
            target0_reg <= target;
        end
    end

    assign pa       = a0_reg * a0_reg;
    assign pb       = b0_reg * b0_reg;
    assign num0_neg = -num0_reg;

    always_comb begin
        side1_next          = '0;
        side1_next.axis     = axis0_reg;
        side1_next.target   = target0_reg;
        side1_next.num_neg  = num0_reg[tal_pkg::NUM_W-1];
        side1_next.num_zero = (num0_reg == '0);
        side1_next.num_abs  = num0_reg[tal_pkg::NUM_W-1] ? num0_neg[tal_pkg::ACC_W-1:0]
                                                        : num0_reg[tal_pkg::ACC_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            sqa1_reg  <= pa;
            sqb1_reg  <= pb;
            side1_reg <= side1_next;
        end
        if (adv[2]) begin
            sum2_reg  <= sqa1_reg + sqb1_reg;
            side2_reg <= side1_reg;
        end
    end

    assign out_valid = v_reg[2];
    assign out_sum   = sum2_reg;
    assign out_side  = side2_reg;
endmodule
`default_nettype wire

FILE: rtl/tal_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module tal_isqrt (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [tal_pkg::SUM_W-1:0] in_sum,
    input  wire tal_pkg::tal_side_t        in_side,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [tal_pkg::DEN_W-1:0]      out_den,
    output tal_pkg::tal_side_t             out_side
);
    localparam int N = tal_pkg::SQRT_STEPS;

    logic [N-1:0] v_reg;
    logic [N-1:0] adv;
    logic [N-1:0] v_in;

    logic [tal_pkg::REM_W-1:0] rem_reg  [N];
    logic [tal_pkg::DEN_W-1:0] root_reg [N];
    logic [tal_pkg::SUM_W-1:0] val_reg  [N];
    tal_pkg::tal_side_t        side_reg [N];

    logic [tal_pkg::REM_W-1:0] rem_in  [N];
    logic [tal_pkg::DEN_W-1:0] root_in [N];
    logic [tal_pkg::SUM_W-1:0] val_in  [N];
    tal_pkg::tal_side_t        side_in [N];

    for (genvar j = 0; j < N; j++) begin : g_step
        logic [tal_pkg::REM_W+1:0] cur;
        logic [tal_pkg::REM_W+1:0] trial;
        logic                      ge;

        if (j == 0) begin : g_first
            assign v_in[j]    = in_valid;
            assign rem_in[j]  = '0;
            assign root_in[j] = '0;
            assign val_in[j]  = in_sum;
            assign side_in[j] = in_side;
        end else begin : g_rest
            assign v_in[j]    = v_reg[j-1];
            assign rem_in[j]  = rem_reg[j-1];
            assign root_in[j] = root_reg[j-1];
            assign val_in[j]  = val_reg[j-1];
            assign side_in[j] = side_reg[j-1];
        end

        if (j == N - 1) begin : g_last
            assign adv[j] = !v_reg[j] || out_ready;
        end else begin : g_mid
            assign adv[j] = !v_reg[j] || adv[j+1];
        end

        // Bring down the next two bits and try to subtract 4*root + 1.
        assign cur   = {rem_in[j], val_in[j][tal_pkg::SUM_W-1-2*j -: 2]};
        assign trial = {2'b00, root_in[j], 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (adv[j]) begin
                v_reg[j] <= v_in[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[j]) begin
                rem_reg[j]  <= ge ? tal_pkg::REM_W'(cur - trial) : tal_pkg::REM_W'(cur);
                root_reg[j] <= {root_in[j][tal_pkg::DEN_W-2:0], ge};
                val_reg[j]  <= val_in[j];
                side_reg[j] <= side_in[j];
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[N-1];
    assign out_den   = root_reg[N-1];

    always_comb begin
        out_side          = side_reg[N-1];
        out_side.den_zero = (root_reg[N-1] == '0);
    end
endmodule
`default_nettype wire

FILE: rtl/tal_cordic.sv
// Pipelined CORDIC in vectoring mode, one rotation per stage.
`default_nettype none
module tal_cordic (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [tal_pkg::DEN_W-1:0] in_den,
    input  wire tal_pkg::tal_side_t        in_side,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed [tal_pkg::Z_W-1:0] out_z,
    output tal_pkg::tal_side_t             out_side
);
    localparam int N   = tal_pkg::CORDIC_STEPS;
    localparam int PAD = tal_pkg::XY_W - tal_pkg::ACC_W - tal_pkg::WORK_SHIFT;

    logic [N-1:0] v_reg;
    logic [N-1:0] adv;
    logic [N-1:0] v_in;

    logic signed [tal_pkg::XY_W-1:0] x_reg [N];
    logic signed [tal_pkg::XY_W-1:0] y_reg [N];
    logic signed [tal_pkg::Z_W-1:0]  z_reg [N];
    tal_pkg::tal_side_t              side_reg [N];

    logic signed [tal_pkg::XY_W-1:0] x_in [N];
    logic signed [tal_pkg::XY_W-1:0] y_in [N];
    logic signed [tal_pkg::Z_W-1:0]  z_in [N];
    tal_pkg::tal_side_t              side_in [N];

    for (genvar i = 0; i < N; i++) begin : g_rot
        logic signed [tal_pkg::XY_W-1:0] xs, ys;

        if (i == 0) begin : g_first
            assign v_in[i]    = in_valid;
            assign x_in[i]    = {{PAD{1'b0}}, in_den, {tal_pkg::WORK_SHIFT{1'b0}}};
            assign y_in[i]    = {{PAD{1'b0}}, in_side.num_abs, {tal_pkg::WORK_SHIFT{1'b0}}};
            assign z_in[i]    = '0;
            assign side_in[i] = in_side;
        end else begin : g_rest
            assign v_in[i]    = v_reg[i-1];
            assign x_in[i]    = x_reg[i-1];
            assign y_in[i]    = y_reg[i-1];
            assign z_in[i]    = z_reg[i-1];
            assign side_in[i] = side_reg[i-1];
        end

        if (i == N - 1) begin : g_last
            assign adv[i] = !v_reg[i] || out_ready;
        end else begin : g_mid
            assign adv[i] = !v_reg[i] || adv[i+1];
        end

        assign xs = x_in[i] >>> i;
        assign ys = y_in[i] >>> i;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (adv[i]) begin
                v_reg[i] <= v_in[i];
            end
        end

        // Rotate toward the x axis and accumulate the angle turned.
        always_ff @(posedge aclk) begin
            if (adv[i]) begin
                if (!y_in[i][tal_pkg::XY_W-1]) begin
                    x_reg[i] <= x_in[i] + ys;
                    y_reg[i] <= y_in[i] - xs;
                    z_reg[i] <= z_in[i] + tal_pkg::ATAN_TAB[i];
                end else begin
                    x_reg[i] <= x_in[i] - ys;
                    y_reg[i] <= y_in[i] + xs;
                    z_reg[i] <= z_in[i] - tal_pkg::ATAN_TAB[i];
                end
                side_reg[i] <= side_in[i];
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[N-1];
    assign out_z     = z_reg[N-1];
    assign out_side  = side_reg[N-1];
endmodule
`default_nettype wire

FILE: rtl/tal_post.sv
// Post stages: scale the angle, form the error to target and the LED levels.
`default_nettype none
`include "tilt_angle_led_level_defines.svh"
module tal_post (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic signed [tal_pkg::Z_W-1:0] in_z,
    input  wire tal_pkg::tal_side_t          in_side,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [tal_pkg::LEVEL_W-1:0]      green_level,
    output logic [tal_pkg::LEVEL_W-1:0]      orange_level,
    output logic [tal_pkg::LEVEL_W-1:0]      red_level,
    output logic [tal_pkg::LEVEL_W-1:0]      blue_level,
    output logic [tal_pkg::MAG_W-1:0]        angle_magnitude,
    output logic                             angle_positive
);
    localparam int P1_W = tal_pkg::ZC_W + tal_pkg::RECIP_W;
    localparam int P2_W = tal_pkg::DIFF_W + tal_pkg::RECIP_W;
    localparam int P3_W = tal_pkg::LV_W + tal_pkg::RECIP9_W;

    logic [3:0] v_reg;
    logic [3:0] adv;

    // Stage 1: clamp, round and divide by 100.
    logic [tal_pkg::ZC_W-1:0]  zc;
    logic [P1_W-1:0]           prod1;
    logic [tal_pkg::MAG_W-1:0] magraw1_reg;
    tal_pkg::tal_side_t        side1_reg;

    // Stage 2: special cases, sign and distance from target.
    logic [tal_pkg::MAG_W-1:0]         mag;
    logic                              pos;
    logic signed [tal_pkg::DIFF_W-1:0] angle_s, tgt100, diff;
    logic [tal_pkg::DIFF_W-1:0]        diff_abs;
    logic [tal_pkg::DIFF_W-1:0]        absd2_reg;
    logic [tal_pkg::MAG_W-1:0]         mag2_reg;
    logic                              pos2_reg, axis2_reg;

    // Stage 3: whole degrees.
    logic [P2_W-1:0]           prod2;
    logic [tal_pkg::DEG_W-1:0] deg3_reg;
    logic [tal_pkg::MAG_W-1:0] mag3_reg;
    logic                      pos3_reg, axis3_reg;

    // Stage 4: level = floor((50*deg - 1) / 9), saturated.
    logic [tal_pkg::LV_W-1:0]    deg50;
    logic [P3_W-1:0]             prod3;
    logic [tal_pkg::LV_W-1:0]    lv_raw;
    logic [tal_pkg::LEVEL_W-1:0] level;
    logic [tal_pkg::LEVEL_W-1:0] green_reg, orange_reg, red_reg, blue_reg;
    logic [tal_pkg::MAG_W-1:0]   mag4_reg;
    logic                        pos4_reg;

    assign adv[3]   = !v_reg[3] || out_ready;
    assign adv[2]   = !v_reg[2] || adv[3];
    assign adv[1]   = !v_reg[1] || adv[2];
    assign adv[0]   = !v_reg[0] || adv[1];
    assign in_ready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) v_reg[0] <= in_valid;
            if (adv[1]) v_reg[1] <= v_reg[0];
            if (adv[2]) v_reg[2] <= v_reg[1];
            if (adv[3]) v_reg[3] <= v_reg[2];
        end
    end

    always_comb begin
        if (in_z[tal_pkg::Z_W-1]) begin
            zc = '0;
        end else if (in_z > $signed({2'b00, tal_pkg::Z_MAX})) begin
            zc = tal_pkg::Z_MAX;
        end else begin
            zc = in_z[tal_pkg::ZC_W-1:0];
        end
    end
    assign prod1 = P1_W'(zc + tal_pkg::Z_ROUND) * P1_W'(tal_pkg::RECIP_100);

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            magraw1_reg <= prod1[tal_pkg::RECIP_100_SH +: tal_pkg::MAG_W];
            side1_reg   <= in_side;
        end
    end

    always_comb begin
        if (side1_reg.num_zero) begin
            mag = '0;
        end else if (side1_reg.den_zero) begin
            mag = tal_pkg::MAG_FULL;
        end else begin
            mag = magraw1_reg;
        end
        pos      = !side1_reg.num_neg && (mag != '0);
        angle_s  = side1_reg.num_neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        tgt100   = tal_pkg::DIFF_W'(side1_reg.target) * 16'sd100;
        diff     = tgt100 - angle_s;
        diff_abs = diff[tal_pkg::DIFF_W-1] ? tal_pkg::DIFF_W'(-diff) : tal_pkg::DIFF_W'(diff);
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            absd2_reg <= diff_abs;
            mag2_reg  <= mag;
            pos2_reg  <= pos;
            axis2_reg <= side1_reg.axis;
        end
    end

    assign prod2 = P2_W'(absd2_reg) * P2_W'(tal_pkg::RECIP_100);

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            deg3_reg  <= prod2[tal_pkg::RECIP_100_SH +: tal_pkg::DEG_W];
            mag3_reg  <= mag2_reg;
            pos3_reg  <= pos2_reg;
            axis3_reg <= axis2_reg;
        end
    end

    always_comb begin
        deg50  = (tal_pkg::LV_W'(deg3_reg) << 5) + (tal_pkg::LV_W'(deg3_reg) << 4)
               + (tal_pkg::LV_W'(deg3_reg) << 1);
        prod3  = P3_W'(deg50 - tal_pkg::LV_W'(1)) * P3_W'(tal_pkg::RECIP_9);
        lv_raw = prod3[tal_pkg::RECIP_9_SH +: tal_pkg::LV_W];
        if (deg3_reg == '0) begin
            level = '0;
        end else if (lv_raw > tal_pkg::LV_W'(tal_pkg::LEVEL_MAX)) begin
            level = tal_pkg::LEVEL_MAX;
        end else begin
            level = lv_raw[tal_pkg::LEVEL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            green_reg  <= ( axis3_reg && !pos3_reg) ? level : '0;
            orange_reg <= (!axis3_reg && !pos3_reg) ? level : '0;
            red_reg    <= ( axis3_reg &&  pos3_reg) ? level : '0;
            blue_reg   <= (!axis3_reg &&  pos3_reg) ? level : '0;
            mag4_reg   <= mag3_reg;
            pos4_reg   <= pos3_reg;
        end
    end

    assign out_valid       = v_reg[3];
    assign green_level     = green_reg;
    assign orange_level    = orange_reg;
    assign red_level       = red_reg;
    assign blue_level      = blue_reg;
    assign angle_magnitude = mag4_reg;
    assign angle_positive  = pos4_reg;

    `TAL_ASSERT(a_one_channel, v_reg[3] |-> $onehot0({green_reg != '0, orange_reg != '0, red_reg != '0, blue_reg != '0}), "more than one LED channel lit")
    `TAL_ASSERT(a_mag_range, v_reg[3] |-> (mag4_reg <= tal_pkg::MAG_FULL), "angle magnitude above 90 degrees")
    `TAL_ASSERT(a_pos_nonzero, (v_reg[3] && pos4_reg) |-> (mag4_reg != '0), "positive angle with zero magnitude")
    `TAL_ASSERT_NEXT(a_stage_move, v_reg[2] && adv[3], v_reg[3], "item lost between last two stages")
endmodule
`default_nettype wire

FILE: bench/tilt_angle_led_level_tb.sv
// Self-checking bench for the tilt angle LED level block: random and corner samples.
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: predicts the LED levels of each accepted sample and checks results in order.
class tilt_level_board;
    bit        axis_pitch;
    logic signed [7:0] target_deg;
    logic [55:0] pending_levels[$];
    int        errors;

    function new();
        axis_pitch = 1'b1;
        target_deg = '0;
        errors     = 0;
    endfunction

    static function longint floor_shift(longint v, int k);
        return v >>> k;
    endfunction

    static function longint int_sqrt(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    static function int cordic_mag(longint n, longint d);
        longint atan_t[16];
        longint xv, yv, zv, xs, ys;
        atan_t = '{450000, 265651, 140362, 71250, 35763, 17899, 8952, 4476,
                   2238, 1119, 560, 280, 140, 70, 35, 17};
        xv = d <<< 16;
        yv = n <<< 16;
        zv = 0;
        for (int i = 0; i < 16; i++) begin
            xs = floor_shift(xv, i);
            ys = floor_shift(yv, i);
            if (yv >= 0) begin
                xv += ys; yv -= xs; zv += atan_t[i];
            end else begin
                xv -= ys; yv += xs; zv -= atan_t[i];
            end
        end
        if (zv < 0) zv = 0;
        if (zv > 900000) zv = 900000;
        zv = (zv + 50) / 100;
        if (zv > 9000) zv = 9000;
        return int'(zv);
    endfunction

    function void note_sample(logic [47:0] d);
        longint ax, ay, az, num, a, b, den, lvl;
        int mag, ang, diff;
        bit pos;
        logic [9:0] l10;
        ax = longint'($signed(d[15:0]));
        ay = longint'($signed(d[31:16]));
        az = longint'($signed(d[47:32]));
        if (axis_pitch) begin
            num = ax; a = ay; b = az;
        end else begin
            num = -ay; a = ax; b = az;
        end
        den = int_sqrt(a * a + b * b);
        if (num == 0) mag = 0;
        else if (den == 0) mag = 9000;
        else mag = cordic_mag(num < 0 ? -num : num, den);
        ang = (num < 0) ? -mag : mag;
        pos = ang > 0;
        diff = int'(target_deg) * 100 - ang;
        if (diff < 0) diff = -diff;
        lvl = (longint'(diff / 100) * 5555555) / 1000000;
        if (lvl > 999) lvl = 999;
        l10 = lvl[9:0];
        pending_levels.push_back({1'b0, pos, mag[13:0],
                                  (!axis_pitch && pos) ? l10 : 10'd0,
                                  (axis_pitch && pos) ? l10 : 10'd0,
                                  (!axis_pitch && !pos) ? l10 : 10'd0,
                                  (axis_pitch && !pos) ? l10 : 10'd0});
    endfunction

    function void check_result(logic [55:0] got);
        logic [55:0] exp_v;
        if (pending_levels.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        exp_v = pending_levels.pop_front();
        if (got[9:0] !== exp_v[9:0] || got[19:10] !== exp_v[19:10] ||
            got[29:20] !== exp_v[29:20] || got[39:30] !== exp_v[39:30] ||
            got[53:40] !== exp_v[53:40] || got[54] !== exp_v[54]) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_v, got);
            errors++;
        end
    endfunction
endclass

module tilt_angle_led_level_tb;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [tal_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tal_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    // Idle odds in percent for the sender and the receiver, changed per phase.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned idle_cycles = 0;
    tilt_level_board board;

    tilt_angle_led_level u_top (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Check each result item; randomize the receiver's ready.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) board.check_result(m_tdata);
            if (s_tvalid && s_tready) board.note_sample(s_tdata);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: count cycles in which no item moves on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Write one register; the block must be idle.
    task automatic write_reg(input logic [tal_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == tal_pkg::REG_TILT_AXIS) board.axis_pitch = val[0];
        else board.target_deg = val;
    endtask

    // Offer one sample item and hold it until accepted; valid stays high so
    // the next item can follow at once.
    task automatic send_sample(input logic [47:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid, hold until every expected result has come, then let the pipe drain.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending_levels.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] rand_target();
        case ($urandom_range(4))
            0: return 8'sd90;
            1: return -8'sd90;
            2: return 8'($urandom);
            default: return 8'($signed($urandom_range(180)) - 90);
        endcase
    endfunction

    logic [47:0] corner_set[$];

    initial begin
        board = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corners: both axes, zero divisor, zero numerator, extremes, tiny angles.
        corner_set = '{
            {16'h0000, 16'h0000, 16'h0000}, {16'h0000, 16'h0000, 16'h7FFF},
            {16'h0000, 16'h0000, 16'h8000}, {16'h0000, 16'h7FFF, 16'h0000},
            {16'h0000, 16'h8000, 16'h0000}, {16'h8000, 16'h8000, 16'h8000},
            {16'h7FFF, 16'h7FFF, 16'h7FFF}, {16'h7FFF, 16'h0001, 16'h0000},
            {16'h7FFF, 16'h0000, 16'h0001}, {16'h0001, 16'h7FFF, 16'h7FFF},
            {16'h8000, 16'hFFFF, 16'h7FFF}, {16'h4000, 16'h4000, 16'h4000}};
        for (int t = 0; t < 3; t++) begin
            for (int ax = 1; ax >= 0; ax--) begin
                write_reg(tal_pkg::REG_TILT_AXIS, 8'(ax));
                write_reg(tal_pkg::REG_TARGET_ANGLE,
                          t == 0 ? 8'd0 : (t == 1 ? 8'sd90 : -8'sd90));
                foreach (corner_set[i]) if (i < 4 || t == 0) send_sample(corner_set[i]);
                drain();
            end
        end

        // Random phases: idle patterns cycle, config changes between phases.
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            write_reg(tal_pkg::REG_TILT_AXIS, 8'($urandom));
            write_reg(tal_pkg::REG_TARGET_ANGLE, rand_target());
            for (int n = 0; n < 100; n++)
                send_sample({rand_axis(), rand_axis(), rand_axis()});
            drain();
        end

        if (board.errors == 0 && board.pending_levels.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+rtl
rtl/tal_pkg.sv
rtl/tal_front.sv
rtl/tal_isqrt.sv
rtl/tal_cordic.sv
rtl/tal_post.sv
rtl/tilt_angle_led_level.sv
bench/tilt_angle_led_level_tb.sv
